>>> src/vca_pkg.sv
// shared constants and types for the valid 2d correlation block
`default_nettype none
package vca_pkg;
	localparam int KMAX        = 7;
	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int COL_BITS    = 10;
	localparam int ROW_BITS    = 10;
	localparam int DIM_BITS    = 11;
	localparam int KIDX_BITS   = 3;
	localparam int LINE_ROWS   = KMAX - 1;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int PSUM_BITS   = PROD_BITS + $clog2(KMAX) + 1;
	localparam int ADDEND_BITS = 38;
	localparam int SUM_BITS    = 40;
	localparam int TOT_BITS    = SUM_BITS + 1;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_COLS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_ROWS = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_ROWS  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_COLS  = 2'd3;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TAP    = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [PSUM_BITS-1:0]   psum_t;
	typedef logic [LINE_ROWS*SAMPLE_BITS-1:0] line_t;
endpackage
`default_nettype wire

>>> src/vca_line.sv
// line buffer memory holding the previous rows of each column
`default_nettype none
module vca_line (
	input  wire logic                        clk,
	input  wire logic [vca_pkg::COL_BITS-1:0] rd_addr,
	output vca_pkg::line_t                   rd_data,
	input  wire logic                        wr_en,
	input  wire logic [vca_pkg::COL_BITS-1:0] wr_addr,
	input  wire vca_pkg::line_t              wr_data
);
	import vca_pkg::*;

	line_t mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> src/vca_cell.sv
// one window column: shifts from its neighbor, multiplies by its taps, sums
`default_nettype none
module vca_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift_en,
	input  wire vca_pkg::sample_t col_in  [vca_pkg::KMAX],
	input  wire vca_pkg::sample_t taps    [vca_pkg::KMAX],
	output vca_pkg::sample_t col_out [vca_pkg::KMAX],
	output vca_pkg::psum_t   psum_s4
);
	import vca_pkg::*;

	sample_t win_q [KMAX];
	logic signed [PROD_BITS-1:0] prod_s3 [KMAX];
	psum_t sum_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KMAX; k++) win_q[k] <= '0;
		end else if (shift_en) begin
			for (int k = 0; k < KMAX; k++) win_q[k] <= col_in[k];
		end
	end

	// rows outside the filter carry zero taps and may hold unwritten line data
	always_ff @(posedge clk) begin
		for (int k = 0; k < KMAX; k++) begin
			if (taps[k] == '0) prod_s3[k] <= '0;
			else prod_s3[k] <= win_q[k] * taps[k];
		end
		psum_s4 <= sum_c;
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < KMAX; k++) sum_c = sum_c + psum_t'(prod_s3[k]);
	end

	assign col_out = win_q;
endmodule
`default_nettype wire

>>> src/valid_conv2d_accumulate.sv
// top level of the streaming valid 2d cross-correlation with accumulate
// usage:
//   in channel: command 0 carries one image sample in raster order, command 1
//   writes one filter tap at tap_row, tap_col; addend is added to the window sum
//   out channel: one word per sample that completes a full window, with its
//   output row, column and a flag on the last output of the frame
//   cfg channel: cfg_index selects image_cols, image_rows, taps_rows, taps_cols;
//   always ready, write only while no word is in flight
// timing:
//   one input word per cycle while in_ready is high; a result passes through the
//   line buffer read, window shift, multiply row of cells, column sums and final
//   add, then the clamped sum is written to an 8-entry queue
// reset:
//   position, window and taps clear to zero, registers to 1024x1024 and 3x3;
//   the line buffer needs no clearing since unwritten rows never reach a result
// stall:
//   when the receiver holds off, the queue absorbs the words in flight and
//   in_ready drops once queue plus pipeline would exceed 8 words
`default_nettype none
module valid_conv2d_accumulate (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               command,
	input  wire logic signed [vca_pkg::SAMPLE_BITS-1:0] sample_value,
	input  wire logic [2:0]                         tap_row,
	input  wire logic [2:0]                         tap_col,
	input  wire logic signed [vca_pkg::ADDEND_BITS-1:0] addend,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [vca_pkg::SUM_BITS-1:0]     window_sum,
	output logic [vca_pkg::ROW_BITS-1:0]            out_row,
	output logic [vca_pkg::COL_BITS-1:0]            out_col,
	output logic                                    frame_last,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [vca_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [vca_pkg::DIM_BITS-1:0]       cfg_data
);
	import vca_pkg::*;

	localparam int QDEPTH = 8;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = QPTR_BITS + 1;
	localparam logic signed [TOT_BITS-1:0] SUM_MAX = TOT_BITS'((64'sd1 <<< (SUM_BITS - 1)) - 1);
	localparam logic signed [TOT_BITS-1:0] SUM_MIN = -TOT_BITS'(64'sd1 <<< (SUM_BITS - 1));

	// configuration
	logic [DIM_BITS-1:0]  cols_q, rows_q, cols_e, rows_e;
	logic [KIDX_BITS-1:0] kr_q, kc_q, kr_e, kc_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= DIM_BITS'(MAX_COLS);
			rows_q <= DIM_BITS'(MAX_ROWS);
			kr_q   <= KIDX_BITS'(3);
			kc_q   <= KIDX_BITS'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_COLS: cols_q <= cfg_data;
				REG_IMAGE_ROWS: rows_q <= cfg_data;
				REG_TAPS_ROWS:  kr_q   <= cfg_data[KIDX_BITS-1:0];
				REG_TAPS_COLS:  kc_q   <= cfg_data[KIDX_BITS-1:0];
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	always_comb begin
		cols_e = (cols_q == '0) ? DIM_BITS'(1) :
			(cols_q > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS) : cols_q;
		rows_e = (rows_q == '0) ? DIM_BITS'(1) :
			(rows_q > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : rows_q;
		kr_e = (kr_q == '0) ? KIDX_BITS'(1) :
			(kr_q > KIDX_BITS'(KMAX)) ? KIDX_BITS'(KMAX) : kr_q;
		kc_e = (kc_q == '0) ? KIDX_BITS'(1) :
			(kc_q > KIDX_BITS'(KMAX)) ? KIDX_BITS'(KMAX) : kc_q;
	end

	// raster position and accept
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] r1, c1;
	logic acc, acc_samp, produce, last_c;
	logic [ROW_BITS-1:0] orow_c;
	logic [COL_BITS-1:0] ocol_c;

	assign acc      = in_valid && in_ready;
	assign acc_samp = acc && (command == CMD_SAMPLE);
	assign r1 = {1'b0, row_q} + DIM_BITS'(1);
	assign c1 = {1'b0, col_q} + DIM_BITS'(1);
	assign produce = (r1 >= DIM_BITS'(kr_e)) && (r1 <= rows_e)
		&& (c1 >= DIM_BITS'(kc_e)) && (c1 <= cols_e);
	assign orow_c = ROW_BITS'(r1 - DIM_BITS'(kr_e));
	assign ocol_c = COL_BITS'(c1 - DIM_BITS'(kc_e));
	assign last_c = (r1 == rows_e) && (c1 == cols_e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc_samp) begin
			if (c1 >= cols_e) begin
				col_q <= '0;
				row_q <= (r1 >= rows_e) ? '0 : r1[ROW_BITS-1:0];
			end else begin
				col_q <= c1[COL_BITS-1:0];
			end
		end
	end

	// stage 1: line buffer read
	logic samp_s1, tap_s1, prod_s1, hit_s1, last_s1;
	sample_t v_s1;
	logic [KIDX_BITS-1:0] trow_s1, tcol_s1;
	logic [COL_BITS-1:0] addr_s1, ocol_s1;
	logic [ROW_BITS-1:0] orow_s1;
	logic signed [ADDEND_BITS-1:0] add_s1;
	line_t rd_data, line_cur, line_new, fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_s1 <= 1'b0;
			tap_s1  <= 1'b0;
			prod_s1 <= 1'b0;
		end else begin
			samp_s1 <= acc_samp;
			tap_s1  <= acc && (command == CMD_TAP);
			prod_s1 <= acc_samp && produce;
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= sample_value;
		trow_s1 <= tap_row;
		tcol_s1 <= tap_col;
		addr_s1 <= col_q;
		hit_s1  <= samp_s1 && (addr_s1 == col_q);
		orow_s1 <= orow_c;
		ocol_s1 <= ocol_c;
		last_s1 <= last_c;
		add_s1  <= addend;
		fwd_q   <= line_new;
	end

	assign line_cur = hit_s1 ? fwd_q : rd_data;
	assign line_new = {v_s1, line_cur[LINE_ROWS*SAMPLE_BITS-1:SAMPLE_BITS]};

	vca_line u_line (
		.clk     (clk),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (samp_s1),
		.wr_addr (addr_s1),
		.wr_data (line_new)
	);

	// taps, realigned to the bottom right of the window
	sample_t tap_q [KMAX][KMAX];
	sample_t eff_q [KMAX][KMAX];
	sample_t eff_c [KMAX][KMAX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KMAX; i++)
				for (int j = 0; j < KMAX; j++) tap_q[i][j] <= '0;
		end else if (tap_s1 && (trow_s1 < KIDX_BITS'(KMAX))
				&& (tcol_s1 < KIDX_BITS'(KMAX))) begin
			tap_q[trow_s1][tcol_s1] <= v_s1;
		end
	end

	always_comb begin
		int ro, co;
		ro = KMAX - int'(kr_e);
		co = KMAX - int'(kc_e);
		for (int i = 0; i < KMAX; i++)
			for (int j = 0; j < KMAX; j++)
				eff_c[i][j] = (i >= ro && j >= co) ? tap_q[i-ro][j-co] : '0;
	end

	always_ff @(posedge clk) begin
		eff_q <= eff_c;
	end

	// row of window cells
	sample_t col_new [KMAX];
	sample_t win     [KMAX][KMAX];
	sample_t taps_j  [KMAX][KMAX];
	psum_t   psum_s4 [KMAX];

	always_comb begin
		for (int k = 0; k < LINE_ROWS; k++)
			col_new[k] = line_cur[k*SAMPLE_BITS +: SAMPLE_BITS];
		col_new[KMAX-1] = v_s1;
		for (int j = 0; j < KMAX; j++)
			for (int i = 0; i < KMAX; i++) taps_j[j][i] = eff_q[i][j];
	end

	for (genvar j = 0; j < KMAX; j++) begin : g_cell
		if (j == KMAX - 1) begin : g_end
			vca_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift_en(samp_s1),
				.col_in(col_new), .taps(taps_j[j]),
				.col_out(win[j]), .psum_s4(psum_s4[j])
			);
		end else begin : g_mid
			vca_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift_en(samp_s1),
				.col_in(win[j+1]), .taps(taps_j[j]),
				.col_out(win[j]), .psum_s4(psum_s4[j])
			);
		end
	end

	// metadata alongside stages 2 to 5
	logic v_s2, v_s3, v_s4, v_s5;
	logic last_s2, last_s3, last_s4, last_s5;
	logic [ROW_BITS-1:0] orow_s2, orow_s3, orow_s4, orow_s5;
	logic [COL_BITS-1:0] ocol_s2, ocol_s3, ocol_s4, ocol_s5;
	logic signed [ADDEND_BITS-1:0] add_s2, add_s3, add_s4;
	logic signed [TOT_BITS-1:0] tot_c, tot_s5;
	logic signed [SUM_BITS-1:0] sat_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= prod_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		orow_s2 <= orow_s1; ocol_s2 <= ocol_s1; last_s2 <= last_s1; add_s2 <= add_s1;
		orow_s3 <= orow_s2; ocol_s3 <= ocol_s2; last_s3 <= last_s2; add_s3 <= add_s2;
		orow_s4 <= orow_s3; ocol_s4 <= ocol_s3; last_s4 <= last_s3; add_s4 <= add_s3;
		orow_s5 <= orow_s4; ocol_s5 <= ocol_s4; last_s5 <= last_s4;
		tot_s5  <= tot_c;
	end

	always_comb begin
		tot_c = TOT_BITS'(add_s4);
		for (int j = 0; j < KMAX; j++) tot_c = tot_c + TOT_BITS'(psum_s4[j]);
		if (tot_s5 > SUM_MAX) sat_c = SUM_MAX[SUM_BITS-1:0];
		else if (tot_s5 < SUM_MIN) sat_c = SUM_MIN[SUM_BITS-1:0];
		else sat_c = tot_s5[SUM_BITS-1:0];
	end

	// output queue
	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic last;
	} res_t;

	res_t q_mem [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic [2:0] inflight;
	logic pop;

	assign pop = out_valid && out_ready;
	assign inflight = 3'(prod_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign in_ready = (QCNT_BITS'(cnt_q) + QCNT_BITS'(inflight)) < QCNT_BITS'(QDEPTH);

	always_ff @(posedge clk) begin
		if (v_s5) q_mem[wr_ptr_q] <= '{sum: sat_c, row: orow_s5, col: ocol_s5, last: last_s5};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s5) wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			cnt_q <= cnt_q + QCNT_BITS'(v_s5) - QCNT_BITS'(pop);
		end
	end

	assign out_valid  = (cnt_q != '0);
	assign window_sum = q_mem[rd_ptr_q].sum;
	assign out_row    = q_mem[rd_ptr_q].row;
	assign out_col    = q_mem[rd_ptr_q].col;
	assign frame_last = q_mem[rd_ptr_q].last;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(QCNT_BITS'(cnt_q) + QCNT_BITS'(inflight)) <= QCNT_BITS'(QDEPTH))
		else $error("queue plus pipeline exceeds queue depth");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc_samp && produce |=> ##4 v_s5)
		else $error("result lost in pipeline");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (cnt_q < QCNT_BITS'(QDEPTH)) || pop)
		else $error("push into full queue");
`endif
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the streaming valid 2d cross-correlation block with accumulate
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import vca_pkg::*;

	localparam longint SUM_HI = 64'sd549755813887;
	localparam longint SUM_LO = -64'sd549755813888;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [SUM_BITS-1:0] sum;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                last;
	} corr_result_t;

	class corr_scoreboard;
		int cols = MAX_COLS, rows = MAX_ROWS, krows = 3, kcols = 3;
		sample_t line_mem[LINE_ROWS][MAX_COLS];
		sample_t win[KMAX][KMAX];
		sample_t taps[KMAX][KMAX];
		int row_pos, col_pos;
		corr_result_t expected_q[$];
		int mismatches, results_seen, samples_seen, tap_writes;

		function new();
			for (int k = 0; k < LINE_ROWS; k++)
				for (int c = 0; c < MAX_COLS; c++)
					line_mem[k][c] = '0;
			for (int k = 0; k < KMAX; k++)
				for (int j = 0; j < KMAX; j++) begin
					win[k][j] = '0;
					taps[k][j] = '0;
				end
		endfunction

		function int clamp_dim(int v, int hi);
			return (v < 1) ? 1 : (v > hi) ? hi : v;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] d);
			case (idx)
				REG_IMAGE_COLS: cols = clamp_dim(int'(d), MAX_COLS);
				REG_IMAGE_ROWS: rows = clamp_dim(int'(d), MAX_ROWS);
				REG_TAPS_ROWS:  krows = clamp_dim(int'(d[2:0]), KMAX);
				REG_TAPS_COLS:  kcols = clamp_dim(int'(d[2:0]), KMAX);
				default: ;
			endcase
		endfunction

		function void note_input(logic cmd, sample_t val, logic [2:0] tr, logic [2:0] tc,
				logic signed [ADDEND_BITS-1:0] add);
			sample_t column[KMAX];
			longint s;
			corr_result_t res;
			int c;
			if (cmd == CMD_TAP) begin
				tap_writes++;
				if (tr < KMAX && tc < KMAX)
					taps[tr][tc] = val;
				return;
			end
			samples_seen++;
			c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
			for (int k = 0; k < LINE_ROWS; k++)
				column[k] = line_mem[k][c];
			column[KMAX-1] = val;
			for (int k = 0; k < LINE_ROWS - 1; k++)
				line_mem[k][c] = line_mem[k+1][c];
			line_mem[LINE_ROWS-1][c] = val;
			for (int k = 0; k < KMAX; k++) begin
				for (int j = 0; j < KMAX - 1; j++)
					win[k][j] = win[k][j+1];
				win[k][KMAX-1] = column[k];
			end
			if (row_pos + 1 >= krows && row_pos + 1 <= rows
					&& col_pos + 1 >= kcols && col_pos + 1 <= cols) begin
				s = 0;
				for (int i = 0; i < krows; i++)
					for (int q = 0; q < kcols; q++)
						s += longint'(win[KMAX-krows+i][KMAX-kcols+q]) * longint'(taps[i][q]);
				s += longint'(add);
				if (s > SUM_HI) s = SUM_HI;
				if (s < SUM_LO) s = SUM_LO;
				res.sum = s[SUM_BITS-1:0];
				res.row = ROW_BITS'(row_pos + 1 - krows);
				res.col = COL_BITS'(col_pos + 1 - kcols);
				res.last = (row_pos + 1 == rows && col_pos + 1 == cols);
				expected_q.push_back(res);
			end
			if (col_pos + 1 >= cols) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
			end else
				col_pos++;
		endfunction

		function void check(logic [SUM_BITS-1:0] sum, logic [ROW_BITS-1:0] row,
				logic [COL_BITS-1:0] col, logic last);
			corr_result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: sum=%0d row=%0d col=%0d last=%0b",
						$signed(sum), row, col, last);
				return;
			end
			e = expected_q.pop_front();
			if (e.sum !== sum || e.row !== row || e.col !== col || e.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp sum=%0d row=%0d col=%0d last=%0b,",
						$signed(e.sum), e.row, e.col, e.last,
						" got sum=%0d row=%0d col=%0d last=%0b",
						$signed(sum), row, col, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = CMD_SAMPLE;
	sample_t sample_value = '0;
	logic [2:0] tap_row = '0;
	logic [2:0] tap_col = '0;
	logic signed [ADDEND_BITS-1:0] addend = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SUM_BITS-1:0] window_sum;
	logic [ROW_BITS-1:0] out_row;
	logic [COL_BITS-1:0] out_col;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [DIM_BITS-1:0] cfg_data = '0;

	corr_scoreboard sb = new();
	int cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int random_words = 0;
	int phases = 0;

	valid_conv2d_accumulate DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .sample_value(sample_value),
		.tap_row(tap_row), .tap_col(tap_col), .addend(addend),
		.out_valid(out_valid), .out_ready(out_ready),
		.window_sum(window_sum), .out_row(out_row), .out_col(out_col),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 128);
		end
		stall_left--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check(window_sum, out_row, out_col, frame_last);

	task automatic send_word(logic cmd, sample_t val, logic [2:0] tr, logic [2:0] tc,
			logic signed [ADDEND_BITS-1:0] add);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		command <= cmd;
		sample_value <= val;
		tap_row <= tr;
		tap_col <= tc;
		addend <= add;
		do @(posedge clk); while (!in_ready);
		sb.note_input(cmd, val, tr, tc, add);
		burst_left--;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_shape(int c, int r, int kr, int kc);
		write_reg(REG_IMAGE_COLS, DIM_BITS'(c));
		write_reg(REG_IMAGE_ROWS, DIM_BITS'(r));
		write_reg(REG_TAPS_ROWS, DIM_BITS'(kr));
		write_reg(REG_TAPS_COLS, DIM_BITS'(kc));
	endtask

	function automatic sample_t rand_value();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic signed [ADDEND_BITS-1:0] rand_addend();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2: return {1'b0, {(ADDEND_BITS-1){1'b1}}};
			3: return {1'b1, {(ADDEND_BITS-1){1'b0}}};
			default: return ADDEND_BITS'({$urandom, $urandom});
		endcase
	endfunction

	// sends random words until the requested number of frames has wrapped, plus a tail
	task automatic run_frames(int frames, int tail);
		int done_frames = 0;
		while (done_frames < frames || tail > 0) begin
			if ($urandom_range(0, 7) == 0)
				send_word(CMD_TAP, rand_value(), 3'($urandom), 3'($urandom), rand_addend());
			else begin
				send_word(CMD_SAMPLE, rand_value(), 3'($urandom), 3'($urandom), rand_addend());
				if (done_frames >= frames)
					tail--;
				else if (sb.row_pos == 0 && sb.col_pos == 0)
					done_frames++;
			end
			random_words++;
		end
		phases++;
		drain();
	endtask

	initial begin
		int c, r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner taps, ignored taps, extreme samples and addends
		set_shape(3, 3, 2, 2);
		send_word(CMD_TAP, 16'sh7fff, 3'd0, 3'd0, '0);
		send_word(CMD_TAP, 16'sh8000, 3'd0, 3'd1, '0);
		send_word(CMD_TAP, 16'sh8000, 3'd1, 3'd0, '0);
		send_word(CMD_TAP, 16'sh7fff, 3'd1, 3'd1, '0);
		send_word(CMD_TAP, 16'sh1234, 3'd6, 3'd6, '0);
		send_word(CMD_TAP, 16'sh7fff, 3'd7, 3'd0, '0);
		send_word(CMD_TAP, 16'sh7fff, 3'd0, 3'd7, '0);
		send_word(CMD_TAP, 16'sh8000, 3'd7, 3'd7, '0);
		send_word(CMD_SAMPLE, 16'sh7fff, 3'd0, 3'd0, '0);
		send_word(CMD_SAMPLE, 16'sh8000, 3'd0, 3'd0, '0);
		send_word(CMD_SAMPLE, 16'sh7fff, 3'd0, 3'd0, '0);
		send_word(CMD_SAMPLE, 16'sh8000, 3'd0, 3'd0, '0);
		send_word(CMD_SAMPLE, 16'sh7fff, 3'd0, 3'd0, {1'b0, {(ADDEND_BITS-1){1'b1}}});
		send_word(CMD_SAMPLE, 16'sh8000, 3'd0, 3'd0, {1'b1, {(ADDEND_BITS-1){1'b0}}});
		send_word(CMD_SAMPLE, 16'sh0000, 3'd0, 3'd0, '1);
		send_word(CMD_SAMPLE, 16'sh7fff, 3'd0, 3'd0, '0);
		send_word(CMD_SAMPLE, 16'sh8000, 3'd0, 3'd0, 38'sd65536);
		drain();

		// extreme shapes, including clamped register values
		set_shape(2047, 1, 0, 7);
		run_frames(1, 0);
		set_shape(1, 1024, 7, 1);
		run_frames(0, 24);
		set_shape(0, 0, 3, 3);
		run_frames(3, 0);
		set_shape(4, 3, 7, 7);
		run_frames(2, 0);

		while (random_words < 1800) begin
			// column count only changes on a frame boundary
			if (sb.row_pos == 0 && sb.col_pos == 0) begin
				c = $urandom_range(1, 12);
				write_reg(REG_IMAGE_COLS, DIM_BITS'(c));
			end
			r = $urandom_range(1, 10);
			write_reg(REG_IMAGE_ROWS, DIM_BITS'(r));
			write_reg(REG_TAPS_ROWS, DIM_BITS'($urandom_range(0, 7)));
			write_reg(REG_TAPS_COLS, DIM_BITS'($urandom_range(0, 7)));
			if ($urandom_range(0, 3) == 0)
				run_frames($urandom_range(0, 2), $urandom_range(1, sb.cols * sb.rows));
			else
				run_frames($urandom_range(1, 3), 0);
		end

		drain();
		if (sb.expected_q.size() != 0) begin
			sb.mismatches += sb.expected_q.size();
			$display("%0d expected words never arrived", sb.expected_q.size());
		end
		if (sb.mismatches > 10)
			$display("%0d further mismatches not shown", sb.mismatches - 10);
		$display("covered %0d phases: %0d samples, %0d tap writes, %0d words checked",
			phases, sb.samples_seen, sb.tap_writes, sb.results_seen);
		$display("%0d mismatches in %0d cycles", sb.mismatches, cycles);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
